// File: design/hsvch_pkg.sv
// hsvch_pkg: widths, class box tables and control state type for the hsv color class histogram
// no dependencies; used by the interfaces, the classifier and the top level
package hsvch_pkg;

    localparam int HSV_WIDTH   = 8;
    localparam int COUNT_WIDTH = 20;
    localparam int COORD_WIDTH = 12;
    localparam int NUM_CLASSES = 11;
    localparam int CLASS_WIDTH = 4;

    localparam logic [CLASS_WIDTH-1:0] LAST_CLASS = CLASS_WIDTH'(NUM_CLASSES - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};

    // inclusive boxes in class order: red, orange, yellow, green, cyan, blue,
    // purple, magenta, black, gray, white
    localparam logic [HSV_WIDTH-1:0] BOX_HUE_LO [NUM_CLASSES] =
        '{8'd0, 8'd8, 8'd23, 8'd36, 8'd81, 8'd93, 8'd131, 8'd144, 8'd0, 8'd0, 8'd0};
    localparam logic [HSV_WIDTH-1:0] BOX_HUE_HI [NUM_CLASSES] =
        '{8'd7, 8'd22, 8'd35, 8'd80, 8'd92, 8'd130, 8'd143, 8'd170, 8'd180, 8'd180, 8'd180};
    localparam logic [HSV_WIDTH-1:0] BOX_SAT_LO [NUM_CLASSES] =
        '{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd0, 8'd0, 8'd0};
    localparam logic [HSV_WIDTH-1:0] BOX_SAT_HI [NUM_CLASSES] =
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd30, 8'd30, 8'd15};
    localparam logic [HSV_WIDTH-1:0] BOX_VAL_LO [NUM_CLASSES] =
        '{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd0, 8'd31, 8'd234};
    localparam logic [HSV_WIDTH-1:0] BOX_VAL_HI [NUM_CLASSES] =
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd30, 8'd233, 8'd255};

    typedef logic [NUM_CLASSES-1:0] class_mask_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } drain_state_t;

endpackage

// File: design/hsvch_pixel_if.sv
// hsvch_pixel_if: valid/ready channel carrying one hsv pixel beat with its position
// depends on hsvch_pkg
interface hsvch_pixel_if
    import hsvch_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [HSV_WIDTH-1:0]   hue;
    logic [HSV_WIDTH-1:0]   saturation;
    logic [HSV_WIDTH-1:0]   brightness;
    logic [COORD_WIDTH-1:0] pixel_row;
    logic [COORD_WIDTH-1:0] pixel_col;
    logic                   frame_end;

    modport source (
        output valid, hue, saturation, brightness, pixel_row, pixel_col, frame_end,
        input  ready
    );
    modport sink (
        input  valid, hue, saturation, brightness, pixel_row, pixel_col, frame_end,
        output ready
    );
endinterface

// File: design/hsvch_result_if.sv
// hsvch_result_if: valid/ready channel carrying one per-class histogram result beat
// depends on hsvch_pkg
interface hsvch_result_if
    import hsvch_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CLASS_WIDTH-1:0] class_index;
    logic [COUNT_WIDTH-1:0] class_count;
    logic [COORD_WIDTH-1:0] first_row;
    logic [COORD_WIDTH-1:0] first_col;
    logic [CLASS_WIDTH-1:0] dominant_class;
    logic                   last_result;

    modport source (
        output valid, class_index, class_count, first_row, first_col, dominant_class,
               last_result,
        input  ready
    );
    modport sink (
        input  valid, class_index, class_count, first_row, first_col, dominant_class,
               last_result,
        output ready
    );
endinterface

// File: design/hsvch_classify.sv
// hsvch_classify: tests one hsv pixel against every class box, one match bit per class
// depends on hsvch_pkg for the box tables
module hsvch_classify
    import hsvch_pkg::*;
(
    input  logic [HSV_WIDTH-1:0] hue,
    input  logic [HSV_WIDTH-1:0] saturation,
    input  logic [HSV_WIDTH-1:0] brightness,
    output class_mask_t          match
);

    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            match[c] = (hue >= BOX_HUE_LO[c]) && (hue <= BOX_HUE_HI[c]) &&
                       (saturation >= BOX_SAT_LO[c]) && (saturation <= BOX_SAT_HI[c]) &&
                       (brightness >= BOX_VAL_LO[c]) && (brightness <= BOX_VAL_HI[c]);
        end
    end

endmodule

// File: design/hsv_color_class_histogram_top.sv
// hsv_color_class_histogram_top: per-frame hsv color class histogram with dominant class
// depends on hsvch_pkg, hsvch_pixel_if, hsvch_result_if and hsvch_classify
// throughput: one pixel beat per cycle; a frame_end beat waits only while the previous
//   frame_end still sits in the input register or its bank is being scanned or drained
// path: a frame_end beat goes through the input register, the bank load and the dominant
//   scan over the bank, then one result per cycle goes out as the sink takes them
// reset: rst_n clears all counts, first-position flags and the drain control at once
module hsv_color_class_histogram_top
    import hsvch_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    hsvch_pixel_if.sink    pixel,
    hsvch_result_if.source result
);

    // input register
    logic                   stage_valid_reg;
    logic                   stage_end_reg;
    logic [HSV_WIDTH-1:0]   stage_hue_reg;
    logic [HSV_WIDTH-1:0]   stage_sat_reg;
    logic [HSV_WIDTH-1:0]   stage_val_reg;
    logic [COORD_WIDTH-1:0] stage_row_reg;
    logic [COORD_WIDTH-1:0] stage_col_reg;

    // live per-class state of the frame in progress
    logic [COUNT_WIDTH-1:0] cnt_reg  [NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] cnt_next [NUM_CLASSES];
    logic                   seen_reg [NUM_CLASSES];
    logic                   seen_next[NUM_CLASSES];
    logic [COORD_WIDTH-1:0] row_reg  [NUM_CLASSES];
    logic [COORD_WIDTH-1:0] row_next [NUM_CLASSES];
    logic [COORD_WIDTH-1:0] col_reg  [NUM_CLASSES];
    logic [COORD_WIDTH-1:0] col_next [NUM_CLASSES];

    // result bank: snapshot of a finished frame, scanned then drained
    logic [COUNT_WIDTH-1:0] bank_cnt_reg[NUM_CLASSES];
    logic [COORD_WIDTH-1:0] bank_row_reg[NUM_CLASSES];
    logic [COORD_WIDTH-1:0] bank_col_reg[NUM_CLASSES];

    // drain control
    drain_state_t           state_reg;
    drain_state_t           state_next;
    logic [CLASS_WIDTH-1:0] idx_reg;
    logic [CLASS_WIDTH-1:0] idx_next;
    logic [COUNT_WIDTH-1:0] best_reg;
    logic [COUNT_WIDTH-1:0] best_next;
    logic [CLASS_WIDTH-1:0] dom_reg;
    logic [CLASS_WIDTH-1:0] dom_next;
    logic                   out_load;

    // result register
    logic                   res_valid_reg;
    logic [CLASS_WIDTH-1:0] res_index_reg;
    logic [COUNT_WIDTH-1:0] res_count_reg;
    logic [COORD_WIDTH-1:0] res_row_reg;
    logic [COORD_WIDTH-1:0] res_col_reg;
    logic [CLASS_WIDTH-1:0] res_dom_reg;
    logic                   res_last_reg;

    class_mask_t            match;
    logic                   accept_in;
    logic                   frame_load;

    // ordinary pixels always go in; a frame_end pixel needs the bank free, counting the
    // frame_end that may already sit in the input register
    assign pixel.ready = !pixel.frame_end ||
                         ((state_reg == ST_IDLE) && !(stage_valid_reg && stage_end_reg));
    assign accept_in   = pixel.valid && pixel.ready;
    assign frame_load  = stage_valid_reg && stage_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            stage_end_reg <= pixel.frame_end;
            stage_hue_reg <= pixel.hue;
            stage_sat_reg <= pixel.saturation;
            stage_val_reg <= pixel.brightness;
            stage_row_reg <= pixel.pixel_row;
            stage_col_reg <= pixel.pixel_col;
        end
    end

    hsvch_classify u_classify (
        .hue        (stage_hue_reg),
        .saturation (stage_sat_reg),
        .brightness (stage_val_reg),
        .match      (match)
    );

    // per-class update: saturating count, first position latched once per frame
    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            cnt_next[c]  = cnt_reg[c];
            seen_next[c] = seen_reg[c];
            row_next[c]  = row_reg[c];
            col_next[c]  = col_reg[c];
            if (stage_valid_reg && match[c])
            begin
                if (cnt_reg[c] != COUNT_MAX)
                begin
                    cnt_next[c] = cnt_reg[c] + 1'b1;
                end
                if (!seen_reg[c])
                begin
                    seen_next[c] = 1'b1;
                    row_next[c]  = stage_row_reg;
                    col_next[c]  = stage_col_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                cnt_reg[c]  <= '0;
                seen_reg[c] <= 1'b0;
                row_reg[c]  <= '0;
                col_reg[c]  <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                // the frame_end pixel counts first, then the live state starts over
                if (frame_load)
                begin
                    cnt_reg[c]  <= '0;
                    seen_reg[c] <= 1'b0;
                    row_reg[c]  <= '0;
                    col_reg[c]  <= '0;
                end
                else
                begin
                    cnt_reg[c]  <= cnt_next[c];
                    seen_reg[c] <= seen_next[c];
                    row_reg[c]  <= row_next[c];
                    col_reg[c]  <= col_next[c];
                end
            end
        end
    end

    // snapshot includes the frame_end pixel's own update
    always_ff @(posedge clk)
    begin
        if (frame_load)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                bank_cnt_reg[c] <= cnt_next[c];
                bank_row_reg[c] <= row_next[c];
                bank_col_reg[c] <= col_next[c];
            end
        end
    end

    // drain sequencer: scan the bank for the first strict maximum, then emit each class
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_load)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_CLASS)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && (idx_reg == LAST_CLASS))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next  = idx_reg;
        best_next = best_reg;
        dom_next  = dom_reg;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next  = '0;
                best_next = '0;
                dom_next  = '0;
            end
            ST_SCAN:
            begin
                // strict compare keeps the earlier class on a tie
                if (bank_cnt_reg[idx_reg] > best_reg)
                begin
                    best_next = bank_cnt_reg[idx_reg];
                    dom_next  = idx_reg;
                end
                idx_next = (idx_reg == LAST_CLASS) ? '0 : idx_reg + 1'b1;
            end
            ST_EMIT:
            begin
                out_load = !res_valid_reg || result.ready;
                if (out_load)
                begin
                    idx_next = (idx_reg == LAST_CLASS) ? '0 : idx_reg + 1'b1;
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            best_reg  <= '0;
            dom_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            best_reg  <= best_next;
            dom_reg   <= dom_next;
        end
    end

    // result register: once the drain is done, a waiting final beat does not block the pixel side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_index_reg <= idx_reg;
            res_count_reg <= bank_cnt_reg[idx_reg];
            res_row_reg   <= bank_row_reg[idx_reg];
            res_col_reg   <= bank_col_reg[idx_reg];
            res_dom_reg   <= dom_reg;
            res_last_reg  <= (idx_reg == LAST_CLASS);
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.class_index    = res_index_reg;
    assign result.class_count    = res_count_reg;
    assign result.first_row      = res_row_reg;
    assign result.first_col      = res_col_reg;
    assign result.dominant_class = res_dom_reg;
    assign result.last_result    = res_last_reg;

    // a frame_end beat never lands on a busy bank
    a_frame_end_bank_free: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready && pixel.frame_end) |->
        ((state_reg == ST_IDLE) && !(stage_valid_reg && stage_end_reg)))
        else $error("frame_end beat accepted while result bank busy");

    // bank load always starts a scan
    a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        frame_load |=> (state_reg == ST_SCAN))
        else $error("bank load did not start dominant scan");

    // last_result marks exactly the final class
    a_last_marks_final: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.last_result == (result.class_index == LAST_CLASS)))
        else $error("last_result out of step with class_index");

    // dominant class is a legal class
    a_dominant_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.dominant_class <= LAST_CLASS))
        else $error("dominant_class out of range");

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking bench for hsv_color_class_histogram_top, with its own per-class box
// classifier, histogram and dominant class pick to predict every result beat
// depends on hsvch_pkg, hsvch_pixel_if, hsvch_result_if and the top level
module tb_top;
    import hsvch_pkg::*;

    localparam int          CLK_PERIOD     = 4;
    localparam int          RESET_CYCLES   = 11;
    localparam int          RANDOM_PIXELS  = 406;
    localparam int unsigned TIMEOUT_CYCLES = 4_000_000;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          MAX_REPORTS    = 10;
    localparam int          QUEUE_HIGH     = 512;
    // largest count a class can hold before it sticks
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = {COUNT_WIDTH{1'b1}};

    typedef enum logic [CLASS_WIDTH-1:0] {
        CL_RED,
        CL_ORANGE,
        CL_YELLOW,
        CL_GREEN,
        CL_CYAN,
        CL_BLUE,
        CL_PURPLE,
        CL_MAGENTA,
        CL_BLACK,
        CL_GRAY,
        CL_WHITE
    } color_class_t;

    typedef struct packed {
        logic [HSV_WIDTH-1:0]   hue;
        logic [HSV_WIDTH-1:0]   sat;
        logic [HSV_WIDTH-1:0]   val;
        logic [COORD_WIDTH-1:0] row;
        logic [COORD_WIDTH-1:0] col;
        logic                   eof;
    } pixel_beat_t;

    // one queued pixel plus the idle cycles the driver inserts ahead of it
    typedef struct {
        pixel_beat_t beat;
        int unsigned gap;
    } pending_pixel_t;

    typedef struct packed {
        color_class_t           cls;
        logic [COUNT_WIDTH-1:0] cnt;
        logic [COORD_WIDTH-1:0] row;
        logic [COORD_WIDTH-1:0] col;
        color_class_t           dom;
        logic                   last;
    } class_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // bench-side copies of the channel controls, all known from time zero
    logic        drv_valid = 1'b0;
    pixel_beat_t drv_beat  = '0;
    logic        snk_ready = 1'b0;

    pending_pixel_t pixel_q[$];
    class_result_t  result_q[$];

    // running histogram of the frame in flight
    logic [COUNT_WIDTH-1:0] hist_count [NUM_CLASSES];
    logic                   hist_seen  [NUM_CLASSES];
    logic [COORD_WIDTH-1:0] hist_row   [NUM_CLASSES];
    logic [COORD_WIDTH-1:0] hist_col   [NUM_CLASSES];

    int          n_errors  = 0;
    int          n_pixels  = 0;
    int          n_frames  = 0;
    int          n_checked = 0;
    int unsigned gap_wait  = 0;
    int unsigned stall_left = 0;
    bit          src_calm  = 1'b0;
    bit          snk_calm  = 1'b0;

    hsvch_pixel_if  pixel_bus ();
    hsvch_result_if result_bus ();

    assign pixel_bus.valid      = drv_valid;
    assign pixel_bus.hue        = drv_beat.hue;
    assign pixel_bus.saturation = drv_beat.sat;
    assign pixel_bus.brightness = drv_beat.val;
    assign pixel_bus.pixel_row  = drv_beat.row;
    assign pixel_bus.pixel_col  = drv_beat.col;
    assign pixel_bus.frame_end  = drv_beat.eof;
    assign result_bus.ready     = snk_ready;

    hsv_color_class_histogram_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_bus),
        .result (result_bus)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ---------------------------------------------------------------
    // class boxes, inclusive on all three axes
    // ---------------------------------------------------------------
    function automatic void get_box(input int c, output int h_lo, output int h_hi,
                                    output int s_lo, output int s_hi,
                                    output int v_lo, output int v_hi);
        // chromatic classes share the strong saturation and value floor
        s_lo = 100;
        s_hi = 255;
        v_lo = 100;
        v_hi = 255;
        case (color_class_t'(c))
            CL_RED:     begin h_lo = 0;   h_hi = 7;   end
            CL_ORANGE:  begin h_lo = 8;   h_hi = 22;  end
            CL_YELLOW:  begin h_lo = 23;  h_hi = 35;  end
            CL_GREEN:   begin h_lo = 36;  h_hi = 80;  end
            CL_CYAN:    begin h_lo = 81;  h_hi = 92;  end
            CL_BLUE:    begin h_lo = 93;  h_hi = 130; end
            CL_PURPLE:  begin h_lo = 131; h_hi = 143; end
            CL_MAGENTA: begin h_lo = 144; h_hi = 170; end
            // achromatic classes span the full hue range
            CL_BLACK:
            begin
                h_lo = 0; h_hi = 180; s_lo = 0; s_hi = 30; v_lo = 0; v_hi = 30;
            end
            CL_GRAY:
            begin
                h_lo = 0; h_hi = 180; s_lo = 0; s_hi = 30; v_lo = 31; v_hi = 233;
            end
            default:
            begin
                h_lo = 0; h_hi = 180; s_lo = 0; s_hi = 15; v_lo = 234; v_hi = 255;
            end
        endcase
    endfunction

    function automatic bit in_class_box(input int c, input pixel_beat_t p);
        int h_lo, h_hi, s_lo, s_hi, v_lo, v_hi;
        get_box(c, h_lo, h_hi, s_lo, s_hi, v_lo, v_hi);
        return int'(p.hue) >= h_lo && int'(p.hue) <= h_hi &&
               int'(p.sat) >= s_lo && int'(p.sat) <= s_hi &&
               int'(p.val) >= v_lo && int'(p.val) <= v_hi;
    endfunction

    // ---------------------------------------------------------------
    // histogram predictor: update on every accepted pixel, and on
    // frame end queue the eleven class results and clear
    // ---------------------------------------------------------------
    task automatic track_pixel(input pixel_beat_t p);
        int                     c;
        logic [COUNT_WIDTH-1:0] best;
        color_class_t           dom;
        class_result_t          r;
        for (c = 0; c < NUM_CLASSES; c++)
        begin
            if (in_class_box(c, p))
            begin
                // count sticks at the top instead of wrapping
                if (hist_count[c] != COUNT_TOP)
                    hist_count[c] = hist_count[c] + 1'b1;
                if (!hist_seen[c])
                begin
                    hist_seen[c] = 1'b1;
                    hist_row[c]  = p.row;
                    hist_col[c]  = p.col;
                end
            end
        end
        if (!p.eof)
            return;
        // first strict maximum wins, red when the frame matched nothing
        best = '0;
        dom  = CL_RED;
        for (c = 0; c < NUM_CLASSES; c++)
        begin
            if (hist_count[c] > best)
            begin
                best = hist_count[c];
                dom  = color_class_t'(c);
            end
        end
        for (c = 0; c < NUM_CLASSES; c++)
        begin
            r.cls  = color_class_t'(c);
            r.cnt  = hist_count[c];
            r.row  = hist_row[c];
            r.col  = hist_col[c];
            r.dom  = dom;
            r.last = (c == NUM_CLASSES - 1);
            result_q.insert(result_q.size(), r);
        end
        clear_histogram();
        n_frames++;
    endtask

    task automatic clear_histogram();
        int c;
        for (c = 0; c < NUM_CLASSES; c++)
        begin
            hist_count[c] = '0;
            hist_seen[c]  = 1'b0;
            hist_row[c]   = '0;
            hist_col[c]   = '0;
        end
    endtask

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    // compare one result beat against the oldest expectation
    task automatic check_class_result();
        class_result_t want;
        n_checked++;
        if (result_q.size() == 0)
        begin
            flag_error($sformatf("result beat with nothing expected, class %0d count %0d",
                                 result_bus.class_index, result_bus.class_count));
            return;
        end
        want = result_q.pop_front();
        if (result_bus.class_index !== want.cls || result_bus.class_count !== want.cnt ||
            result_bus.first_row !== want.row || result_bus.first_col !== want.col ||
            result_bus.dominant_class !== want.dom || result_bus.last_result !== want.last)
        begin
            flag_error($sformatf({"class/count/row/col/dom/last expected %0d/%0d/%0d/%0d/%0d/%0b",
                                  " got %0d/%0d/%0d/%0d/%0d/%0b"},
                                 want.cls, want.cnt, want.row, want.col, want.dom, want.last,
                                 result_bus.class_index, result_bus.class_count,
                                 result_bus.first_row, result_bus.first_col,
                                 result_bus.dominant_class, result_bus.last_result));
        end
    endtask

    // idle length: mostly none or short, now and then long; calm stretches have none
    function automatic int unsigned pick_idle(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // value at, just inside or just outside a box edge, clamped to 8 bits
    function automatic logic [HSV_WIDTH-1:0] near_edge(input int lo, input int hi);
        int v;
        case ($urandom_range(0, 4))
            0:       v = lo;
            1:       v = hi;
            2:       v = lo - 1;
            3:       v = hi + 1;
            default: v = $urandom_range(lo, hi);
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return HSV_WIDTH'(v);
    endfunction

    task automatic random_hsv(output logic [HSV_WIDTH-1:0] h, output logic [HSV_WIDTH-1:0] s,
                              output logic [HSV_WIDTH-1:0] v);
        int m, c;
        int h_lo, h_hi, s_lo, s_hi, v_lo, v_hi;
        m = $urandom_range(0, 99);
        if (m < 70)
        begin
            // aim at the edges of one class box
            c = $urandom_range(0, NUM_CLASSES - 1);
            get_box(c, h_lo, h_hi, s_lo, s_hi, v_lo, v_hi);
            h = near_edge(h_lo, h_hi);
            s = near_edge(s_lo, s_hi);
            v = near_edge(v_lo, v_hi);
        end
        else if (m < 85)
        begin
            h = HSV_WIDTH'($urandom);
            s = HSV_WIDTH'($urandom);
            v = HSV_WIDTH'($urandom);
        end
        else
        begin
            // hue gap above magenta and hues past the legal scale
            h = HSV_WIDTH'($urandom_range(171, 255));
            s = HSV_WIDTH'($urandom);
            v = HSV_WIDTH'($urandom);
        end
    endtask

    // queue one pixel for the driver, holding off while the queue is deep
    task automatic queue_pixel(input int h, input int s, input int v,
                               input int row, input int col, input bit eof);
        pending_pixel_t item;
        while (pixel_q.size() >= QUEUE_HIGH)
            @(posedge clk);
        item.beat.hue = HSV_WIDTH'(h);
        item.beat.sat = HSV_WIDTH'(s);
        item.beat.val = HSV_WIDTH'(v);
        item.beat.row = COORD_WIDTH'(row);
        item.beat.col = COORD_WIDTH'(col);
        item.beat.eof = eof;
        item.gap      = pick_idle(src_calm);
        pixel_q.insert(pixel_q.size(), item);
    endtask

    // ---------------------------------------------------------------
    // pixel driver: presents queued beats, honoring each beat's lead gap;
    // a beat stays on the bus until ready takes it
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_beat  <= '0;
            gap_wait  = 0;
        end
        else
        begin
            // beat taken at this edge goes to the predictor
            if (drv_valid && pixel_bus.ready)
            begin
                track_pixel(drv_beat);
                n_pixels++;
            end
            if (!drv_valid || pixel_bus.ready)
            begin
                if (pixel_q.size() != 0 && gap_wait >= pixel_q[0].gap)
                begin
                    drv_beat  <= pixel_q.pop_front().beat;
                    drv_valid <= 1'b1;
                    gap_wait  = 0;
                end
                else
                begin
                    drv_valid <= 1'b0;
                    if (pixel_q.size() != 0)
                        gap_wait++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor: checks each accepted beat, then picks the next stall
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snk_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_bus.valid && snk_ready)
            begin
                check_class_result();
                stall_left = pick_idle(snk_calm);
                // switch between calm and stalling stretches at frame boundaries
                if (result_bus.last_result)
                    snk_calm = ($urandom_range(0, 3) == 0);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                snk_ready <= 1'b0;
            end
            else
            begin
                snk_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial
    begin
        int                     k, flen, n_random;
        logic [HSV_WIDTH-1:0]   h, s, v;
        logic [COORD_WIDTH-1:0] row, col;

        clear_histogram();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // every class once at a box corner: all counts tie, red wins
        queue_pixel(0, 100, 100, 0, 0, 1'b0);
        queue_pixel(22, 255, 255, 0, 1, 1'b0);
        queue_pixel(35, 100, 255, 0, 2, 1'b0);
        queue_pixel(36, 255, 100, 0, 3, 1'b0);
        queue_pixel(92, 100, 100, 1, 0, 1'b0);
        queue_pixel(93, 255, 255, 1, 1, 1'b0);
        queue_pixel(143, 100, 255, 1, 2, 1'b0);
        queue_pixel(170, 255, 255, 1, 3, 1'b0);
        queue_pixel(180, 30, 30, 2, 0, 1'b0);
        queue_pixel(0, 0, 31, 2, 1, 1'b0);
        queue_pixel(180, 15, 255, 4095, 4095, 1'b1);

        // empty frame: hue gap, hue past 180, just-missed edges, gray/white gap
        queue_pixel(175, 200, 200, 0, 0, 1'b0);
        queue_pixel(255, 255, 255, 0, 1, 1'b0);
        queue_pixel(50, 99, 255, 0, 2, 1'b0);
        queue_pixel(0, 31, 0, 0, 3, 1'b0);
        queue_pixel(181, 0, 0, 0, 4, 1'b0);
        queue_pixel(0, 16, 234, 0, 5, 1'b0);
        queue_pixel(10, 99, 99, 0, 6, 1'b1);

        // blue and gray tie at two, blue comes first
        queue_pixel(90, 30, 233, 3, 7, 1'b0);
        queue_pixel(0, 0, 100, 3, 8, 1'b0);
        queue_pixel(0, 0, 234, 3, 9, 1'b0);
        queue_pixel(100, 200, 200, 3, 10, 1'b0);
        queue_pixel(130, 100, 100, 3, 11, 1'b1);

        // one-pixel frame right behind the previous frame end
        queue_pixel(81, 255, 255, 4095, 4095, 1'b1);

        // random raster-order frames, mostly short, now and then single pixels
        n_random = 0;
        while (n_random < RANDOM_PIXELS)
        begin
            src_calm = ($urandom_range(0, 3) == 0);
            flen     = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
            row      = COORD_WIDTH'($urandom);
            col      = COORD_WIDTH'($urandom);
            for (k = 0; k < flen; k++)
            begin
                random_hsv(h, s, v);
                // occasional jump in position
                if ($urandom_range(0, 7) == 0)
                begin
                    row = COORD_WIDTH'($urandom);
                    col = COORD_WIDTH'($urandom);
                end
                queue_pixel(int'(h), int'(s), int'(v), int'(row), int'(col), k == flen - 1);
                {row, col} = {row, col} + 1'b1;
                n_random++;
            end
        end

        // wait for the last beat to go out and every result to come back
        while (pixel_q.size() != 0 || drv_valid)
            @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
        // watch a while longer for stray result beats
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (result_q.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", result_q.size()));

        $display("covered %0d frames, %0d pixel beats and %0d result beats checked", n_frames,
                 n_pixels, n_checked);
        $display("box corners, empty and tied frames, one-pixel frames and the hue gap included");
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results still expected", result_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
design/hsvch_pkg.sv
design/hsvch_pixel_if.sv
design/hsvch_result_if.sv
design/hsvch_classify.sv
design/hsv_color_class_histogram_top.sv
sim/tb_top.sv
